/* rtl/dcrl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dcrl_pkg: shared constants for the drive command ramp limiter
// Key codes, held-flag positions, register indexes and reset values.
// ----------------------------------------------------------------------------
package dcrl_pkg;

   // default number of fraction bits of a drive level
   localparam int LEVEL_FRAC_BITS_DEF = 14;

   // step width: (16-bit rate * 16-bit time) >> 16
   localparam int RATE_W = 16;
   localparam int STEP_W = 16;
   localparam int DB_W   = 15;

   // command codes
   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // key character codes
   localparam logic [7:0] KEY_CODE_W = 8'h77;
   localparam logic [7:0] KEY_CODE_S = 8'h73;
   localparam logic [7:0] KEY_CODE_A = 8'h61;
   localparam logic [7:0] KEY_CODE_D = 8'h64;

   // held-flag bit positions
   localparam int HELD_N = 5;
   localparam logic [2:0] HELD_ACCEL   = 3'd0;
   localparam logic [2:0] HELD_REVERSE = 3'd1;
   localparam logic [2:0] HELD_BRAKE   = 3'd2;
   localparam logic [2:0] HELD_LEFT    = 3'd3;
   localparam logic [2:0] HELD_RIGHT   = 3'd4;

   // register indexes (byte address = 4 * index)
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_ENGINE_RATE = 3'd0;
   localparam logic [2:0] REG_BRAKE_RATE  = 3'd1;
   localparam logic [2:0] REG_STEER_RATE  = 3'd2;
   localparam logic [2:0] REG_DEADBAND    = 3'd3;
   localparam logic [2:0] REG_KEYS_EN     = 3'd4;

   // register reset values
   localparam logic [RATE_W-1:0] RATE_RST     = 16'd16384;
   localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd164;

endpackage
`default_nettype wire

/* rtl/drive_command_ramp_limiter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drive_command_ramp_limiter: ramped drive levels from held control keys
// Key events set or clear held flags; each tick ramps engine, brake and
// steering levels by rate * time_step >> 16 and emits the three levels.
// ----------------------------------------------------------------------------
// A tick transfer reaches its result through the input register, then the
// result register. Key events produce no result. Throughput: one item per
// cycle unless a tick meets a stalled result; the level update is a single
// pass of multiply, add and clamp between the input and result registers.
// Reset: synchronous, active high; clears held keys and levels, loads the
// register reset values. No clearing pass.
module drive_command_ramp_limiter
   import dcrl_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_cmd,
   input  wire logic [7:0]                        req_key_char,
   input  wire logic                              req_key_is_space,
   input  wire logic                              req_key_down,
   input  wire logic [15:0]                       req_time_step,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [LEVEL_FRAC_BITS+1:0]      rsp_engine_drive,
   output logic        [LEVEL_FRAC_BITS:0]        rsp_brake_drive,
   output logic signed [LEVEL_FRAC_BITS+1:0]      rsp_steer_drive,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [CSR_ADDR_W-1:0]             paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int LW = LEVEL_FRAC_BITS + 2;   // signed level width
   localparam int BW = LEVEL_FRAC_BITS + 1;   // brake level width
   // working width: room for level plus a full step, plus a sign
   localparam int SW = ((LW > STEP_W + 1) ? LW : (STEP_W + 1)) + 1;

   localparam logic signed [SW-1:0] ONE_S =
      {{(SW-LEVEL_FRAC_BITS-1){1'b0}}, 1'b1, {LEVEL_FRAC_BITS{1'b0}}};
   localparam logic signed [SW-1:0] NEG_ONE_S = -ONE_S;
   localparam logic signed [SW-1:0] ZERO_S    = '0;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   logic [RATE_W-1:0] engine_rate_ff, brake_rate_ff, steer_rate_ff;
   logic [DB_W-1:0]   deadband_ff;
   logic              keys_en_ff;

   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [7:0]        in_char_ff;
   logic              in_space_ff;
   logic              in_down_ff;
   logic [15:0]       in_ts_ff;

   logic [HELD_N-1:0]   held_ff, held_in;
   logic signed [LW-1:0] engine_ff, engine_in;
   logic [BW-1:0]        brake_ff, brake_in;
   logic signed [LW-1:0] steer_ff, steer_in;

   logic                 rsp_valid_ff;
   logic signed [LW-1:0] rsp_engine_ff;
   logic [BW-1:0]        rsp_brake_ff;
   logic signed [LW-1:0] rsp_steer_ff;

   logic advance;
   logic req_xfer;
   logic is_tick;
   logic csr_wr;
   logic [2:0] csr_idx;

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         engine_rate_ff <= RATE_RST;
         brake_rate_ff  <= RATE_RST;
         steer_rate_ff  <= RATE_RST;
         deadband_ff    <= DEADBAND_RST;
         keys_en_ff     <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ENGINE_RATE: engine_rate_ff <= pwdata[RATE_W-1:0];
            REG_BRAKE_RATE:  brake_rate_ff  <= pwdata[RATE_W-1:0];
            REG_STEER_RATE:  steer_rate_ff  <= pwdata[RATE_W-1:0];
            REG_DEADBAND:    deadband_ff    <= pwdata[DB_W-1:0];
            REG_KEYS_EN:     keys_en_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENGINE_RATE: prdata = {16'd0, engine_rate_ff};
         REG_BRAKE_RATE:  prdata = {16'd0, brake_rate_ff};
         REG_STEER_RATE:  prdata = {16'd0, steer_rate_ff};
         REG_DEADBAND:    prdata = {17'd0, deadband_ff};
         REG_KEYS_EN:     prdata = {31'd0, keys_en_ff};
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // handshake: a key event always moves on, a tick needs the result slot
   // ------------------------------------------------------------------
   assign is_tick   = (in_cmd_ff == CMD_TICK);
   assign advance   = in_valid_ff && (!is_tick || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff   <= req_cmd;
         in_char_ff  <= req_key_char;
         in_space_ff <= req_key_is_space;
         in_down_ff  <= req_key_down;
         in_ts_ff    <= req_time_step;
      end
   end

   // ------------------------------------------------------------------
   // key decode: 'w' is independent of the s/a/d/space chain
   // ------------------------------------------------------------------
   always_comb begin
      held_in = held_ff;
      if (in_char_ff == KEY_CODE_W) held_in[HELD_ACCEL] = in_down_ff;
      priority if (in_char_ff == KEY_CODE_S) held_in[HELD_REVERSE] = in_down_ff;
      else if (in_char_ff == KEY_CODE_A)     held_in[HELD_LEFT]    = in_down_ff;
      else if (in_char_ff == KEY_CODE_D)     held_in[HELD_RIGHT]   = in_down_ff;
      else if (in_space_ff)                  held_in[HELD_BRAKE]   = in_down_ff;
      else ;
   end

   // ------------------------------------------------------------------
   // ramp steps
   // ------------------------------------------------------------------
   logic [2*RATE_W-1:0] e_prod, b_prod, s_prod;
   logic signed [SW-1:0] es_w, bs_w, ss_w;

   assign e_prod = engine_rate_ff * in_ts_ff;
   assign b_prod = brake_rate_ff  * in_ts_ff;
   assign s_prod = steer_rate_ff  * in_ts_ff;
   assign es_w = {{(SW-STEP_W){1'b0}}, e_prod[2*RATE_W-1:RATE_W]};
   assign bs_w = {{(SW-STEP_W){1'b0}}, b_prod[2*RATE_W-1:RATE_W]};
   assign ss_w = {{(SW-STEP_W){1'b0}}, s_prod[2*RATE_W-1:RATE_W]};

   // ------------------------------------------------------------------
   // level update
   // ------------------------------------------------------------------
   logic signed [SW-1:0] e_w, e_up, e_upc, e_base, e_dn, e_dnc, e_new;
   logic signed [SW-1:0] b_w, b_up, b_new;
   logic signed [SW-1:0] s_w, s_up, s_upc, s_base, s_dn, s_dnc, s_new;
   logic signed [SW-1:0] s_mag, s_ret_dn, s_ret_up;
   logic signed [SW-1:0] db_w;

   always_comb begin
      // engine: accelerate then reverse
      e_w    = {{(SW-LW){engine_ff[LW-1]}}, engine_ff};
      e_up   = e_w + es_w;
      e_upc  = (e_up > ONE_S) ? ONE_S : e_up;
      e_base = held_ff[HELD_ACCEL] ? e_upc : e_w;
      e_dn   = e_base - es_w;
      e_dnc  = (e_dn < NEG_ONE_S) ? NEG_ONE_S : e_dn;
      priority if (held_ff[HELD_REVERSE]) e_new = e_dnc;
      else if (held_ff[HELD_ACCEL])       e_new = e_upc;
      else                                e_new = ZERO_S;

      // brake
      b_w   = {{(SW-BW){1'b0}}, brake_ff};
      b_up  = b_w + bs_w;
      b_new = !held_ff[HELD_BRAKE] ? ZERO_S : ((b_up > ONE_S) ? ONE_S : b_up);

      // steering: left then right, else return towards centre
      s_w    = {{(SW-LW){steer_ff[LW-1]}}, steer_ff};
      s_up   = s_w + ss_w;
      s_upc  = (s_up > ONE_S) ? ONE_S : s_up;
      s_base = held_ff[HELD_LEFT] ? s_upc : s_w;
      s_dn   = s_base - ss_w;
      s_dnc  = (s_dn < NEG_ONE_S) ? NEG_ONE_S : s_dn;
      s_mag  = (s_w < ZERO_S) ? -s_w : s_w;
      db_w   = {{(SW-DB_W){1'b0}}, deadband_ff};
      s_ret_dn = ((s_w - ss_w) < NEG_ONE_S) ? NEG_ONE_S : (s_w - ss_w);
      s_ret_up = ((s_w + ss_w) > ONE_S) ? ONE_S : (s_w + ss_w);
      priority if (held_ff[HELD_RIGHT]) s_new = s_dnc;
      else if (held_ff[HELD_LEFT])      s_new = s_upc;
      else if (s_mag < db_w)            s_new = ZERO_S;
      else if (s_w > ZERO_S)            s_new = s_ret_dn;   // may cross zero
      else if (s_w < ZERO_S)            s_new = s_ret_up;
      else                              s_new = s_w;

      engine_in = e_new[LW-1:0];
      brake_in  = b_new[BW-1:0];
      steer_in  = s_new[LW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         engine_ff <= '0;
         brake_ff  <= '0;
         steer_ff  <= '0;
      end else if (advance) begin
         if (is_tick) begin
            engine_ff <= engine_in;
            brake_ff  <= brake_in;
            steer_ff  <= steer_in;
         end else if (keys_en_ff) begin
            held_ff <= held_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && is_tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_tick) begin
         rsp_engine_ff <= engine_in;
         rsp_brake_ff  <= brake_in;
         rsp_steer_ff  <= steer_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_engine_drive = rsp_engine_ff;
   assign rsp_brake_drive  = rsp_brake_ff;
   assign rsp_steer_drive  = rsp_steer_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   localparam logic signed [LW-1:0] ONE_L     = ONE_S[LW-1:0];
   localparam logic signed [LW-1:0] NEG_ONE_L = NEG_ONE_S[LW-1:0];
   localparam logic [BW-1:0]        ONE_B     = ONE_S[BW-1:0];

   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_cmd_ff == CMD_TICK))
      else $error("result raised without a tick transfer");

   a_levels_bounded: assert property (@(posedge clock) disable iff (reset)
      (engine_ff <= ONE_L) && (engine_ff >= NEG_ONE_L) &&
      (steer_ff <= ONE_L) && (steer_ff >= NEG_ONE_L) && (brake_ff <= ONE_B))
      else $error("drive level outside its range");

   a_keys_disabled: assert property (@(posedge clock) disable iff (reset)
      !keys_en_ff |=> $stable(held_ff))
      else $error("held keys changed while key events are disabled");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_ts_ff) &&
      $stable(in_cmd_ff))
      else $error("stalled tick lost from the input register");

endmodule
`default_nettype wire

/* dv/drive_command_ramp_limiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_ramp_limiter_tb: self-checking bench for the ramp limiter
// A directed table of key events and ticks runs first, then random traffic
// over several register settings. Every tick result is compared with a table
// value or an in-bench model of the held keys and the three ramped levels.
// ----------------------------------------------------------------------------
module drive_command_ramp_limiter_tb;
   import dcrl_pkg::*;

   localparam int  FRAC        = LEVEL_FRAC_BITS_DEF;
   localparam longint LVL_ONE  = longint'(1) << FRAC;
   localparam int  N_PHASES    = 8;
   localparam int  PHASE_ITEMS = 228;
   localparam int  CYCLE_LIMIT = 400000;
   localparam logic [7:0] SPACE_CODE = 8'h20;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  key_char;
      logic        key_is_space;
      logic        key_down;
      logic [15:0] time_step;
   } drive_item_type;

   typedef struct packed {
      logic signed [15:0] engine;
      logic [14:0]        brake;
      logic signed [15:0] steer;
   } drive_levels_type;

   // one directed row: the item, then a typed result where known is set
   typedef struct packed {
      drive_item_type   item;
      logic             known;
      drive_levels_type levels;
   } drive_row_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_cmd          = CMD_KEY;
   logic [7:0]  req_key_char     = 8'h00;
   logic        req_key_is_space = 1'b0;
   logic        req_key_down     = 1'b0;
   logic [15:0] req_time_step    = 16'h0000;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_engine_drive;
   logic [14:0]        rsp_brake_drive;
   logic signed [15:0] rsp_steer_drive;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]           pwdata  = 32'h0;
   logic [31:0]           prdata;
   logic                  pready;

   drive_command_ramp_limiter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_key_char     (req_key_char),
      .req_key_is_space (req_key_is_space),
      .req_key_down     (req_key_down),
      .req_time_step    (req_time_step),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_engine_drive (rsp_engine_drive),
      .rsp_brake_drive  (rsp_brake_drive),
      .rsp_steer_drive  (rsp_steer_drive),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // model state
   logic [15:0]       cfg_engine_rate = RATE_RST;
   logic [15:0]       cfg_brake_rate  = RATE_RST;
   logic [15:0]       cfg_steer_rate  = RATE_RST;
   logic [14:0]       cfg_deadband    = DEADBAND_RST;
   logic              cfg_keys_en     = 1'b1;
   logic [HELD_N-1:0] key_held        = '0;
   longint            engine_lvl      = 0;
   longint            brake_lvl       = 0;
   longint            steer_lvl       = 0;

   drive_levels_type pending_levels[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            burst_left  = 0;
   int            stall_left  = 0;
   int            free_left   = 0;

   drive_row_type directed_rows [25] = '{
      //  cmd       key         spc   down  time_step   known engine       brake     steer
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd0},     1'b1, '{16'sd0,      15'd0,     16'sd0}},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b1, '{16'sd0,      15'd0,     16'sd0}},
      '{'{CMD_KEY,  KEY_CODE_W, 1'b0, 1'b1, 16'd0},     1'b0, '0},
      '{'{CMD_KEY,  SPACE_CODE, 1'b1, 1'b1, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b1, '{16'sd16383,  15'd16383, 16'sd0}},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b1, '{16'sd16384,  15'd16384, 16'sd0}},
      '{'{CMD_KEY,  KEY_CODE_S, 1'b0, 1'b1, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b0, '0},
      '{'{CMD_KEY,  KEY_CODE_W, 1'b0, 1'b0, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b1, '{-16'sd16384, 15'd16384, 16'sd0}},
      '{'{CMD_KEY,  KEY_CODE_A, 1'b1, 1'b1, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd8000},  1'b0, '0},
      '{'{CMD_KEY,  KEY_CODE_D, 1'b0, 1'b1, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd8000},  1'b0, '0},
      '{'{CMD_KEY,  KEY_CODE_A, 1'b0, 1'b0, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd4000},  1'b0, '0},
      '{'{CMD_KEY,  KEY_CODE_D, 1'b0, 1'b0, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd6000},  1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd1400},  1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd0},     1'b0, '0},
      '{'{CMD_KEY,  KEY_CODE_W, 1'b1, 1'b0, 16'd0},     1'b0, '0},
      '{'{CMD_KEY,  8'hFF,      1'b0, 1'b1, 16'd65535}, 1'b0, '0},
      '{'{CMD_KEY,  KEY_CODE_S, 1'b0, 1'b0, 16'd0},     1'b0, '0},
      '{'{CMD_TICK, 8'h00,      1'b0, 1'b0, 16'd65535}, 1'b1, '{16'sd0,      15'd0,     16'sd0}}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: free stretches and stall runs, mostly short, now and then long
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (free_left != 0) begin
         rsp_stall <= 1'b0;
         free_left <= free_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         free_left  <= $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 4);
         stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(1, 3);
      end
   end

   // result check, sampled mid-cycle ahead of the transfer edge
   always @(negedge clock) begin
      drive_levels_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result engine %0d brake %0d steer %0d", $time,
                     rsp_engine_drive, rsp_brake_drive, rsp_steer_drive);
            error_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_engine_drive !== want.engine) begin
               $display("%0t: engine_drive expected %0d, got %0d", $time,
                        want.engine, rsp_engine_drive);
               error_count++;
            end
            if (rsp_brake_drive !== want.brake) begin
               $display("%0t: brake_drive expected %0d, got %0d", $time,
                        want.brake, rsp_brake_drive);
               error_count++;
            end
            if (rsp_steer_drive !== want.steer) begin
               $display("%0t: steer_drive expected %0d, got %0d", $time,
                        want.steer, rsp_steer_drive);
               error_count++;
            end
         end
      end
   end

   function automatic longint clamp_lvl(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // applies one item to the held keys and levels; returns 1 for a tick
   function automatic bit predict_drive_levels(input drive_item_type it,
                                               output drive_levels_type lv);
      longint es, bs, ss, mag;
      lv = '0;
      if (it.cmd == CMD_KEY) begin
         if (cfg_keys_en) begin
            if (it.key_char == KEY_CODE_W) key_held[HELD_ACCEL] = it.key_down;
            if (it.key_char == KEY_CODE_S) key_held[HELD_REVERSE] = it.key_down;
            else if (it.key_char == KEY_CODE_A) key_held[HELD_LEFT] = it.key_down;
            else if (it.key_char == KEY_CODE_D) key_held[HELD_RIGHT] = it.key_down;
            else if (it.key_is_space) key_held[HELD_BRAKE] = it.key_down;
         end
         return 1'b0;
      end
      es = (longint'(cfg_engine_rate) * longint'(it.time_step)) >> 16;
      bs = (longint'(cfg_brake_rate) * longint'(it.time_step)) >> 16;
      ss = (longint'(cfg_steer_rate) * longint'(it.time_step)) >> 16;

      if (key_held[HELD_ACCEL]) engine_lvl = clamp_lvl(engine_lvl + es, -LVL_ONE, LVL_ONE);
      if (key_held[HELD_REVERSE]) engine_lvl = clamp_lvl(engine_lvl - es, -LVL_ONE, LVL_ONE);
      if (!key_held[HELD_ACCEL] && !key_held[HELD_REVERSE]) engine_lvl = 0;

      brake_lvl = key_held[HELD_BRAKE] ? clamp_lvl(brake_lvl + bs, 0, LVL_ONE) : 0;

      if (key_held[HELD_LEFT]) steer_lvl = clamp_lvl(steer_lvl + ss, -LVL_ONE, LVL_ONE);
      if (key_held[HELD_RIGHT]) steer_lvl = clamp_lvl(steer_lvl - ss, -LVL_ONE, LVL_ONE);
      if (!key_held[HELD_LEFT] && !key_held[HELD_RIGHT]) begin
         // released: snap inside the deadband, else one step back (may cross zero)
         mag = (steer_lvl < 0) ? -steer_lvl : steer_lvl;
         if (mag < longint'(cfg_deadband)) steer_lvl = 0;
         else if (steer_lvl > 0) steer_lvl = clamp_lvl(steer_lvl - ss, -LVL_ONE, LVL_ONE);
         else if (steer_lvl < 0) steer_lvl = clamp_lvl(steer_lvl + ss, -LVL_ONE, LVL_ONE);
      end

      lv.engine = engine_lvl[15:0];
      lv.brake  = brake_lvl[14:0];
      lv.steer  = steer_lvl[15:0];
      return 1'b1;
   endfunction

   function automatic drive_item_type random_item(input int tick_pct);
      drive_item_type it;
      it.cmd          = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_KEY;
      it.key_is_space = ($urandom_range(0, 9) == 0);
      it.key_down     = ($urandom_range(0, 9) < 6);
      case ($urandom_range(0, 9))
         0, 1:    it.key_char = KEY_CODE_W;
         2:       it.key_char = KEY_CODE_S;
         3:       it.key_char = KEY_CODE_A;
         4:       it.key_char = KEY_CODE_D;
         5, 6: begin
            it.key_char     = SPACE_CODE;
            it.key_is_space = 1'b1;
         end
         default: it.key_char = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       it.time_step = 16'd0;
         1:       it.time_step = 16'hFFFF;
         2, 3:    it.time_step = 16'($urandom);
         default: it.time_step = 16'($urandom_range(0, 1500));
      endcase
      return it;
   endfunction

   // drives one item and holds it until the transfer; known selects a typed result
   task automatic send_item(input drive_item_type it, input logic known,
                            input drive_levels_type typed_lv);
      drive_levels_type lv;
      bit taken;
      req_valid        <= 1'b1;
      req_cmd          <= it.cmd;
      req_key_char     <= it.key_char;
      req_key_is_space <= it.key_is_space;
      req_key_down     <= it.key_down;
      req_time_step    <= it.time_step;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      if (predict_drive_levels(it, lv)) pending_levels.push_back(known ? typed_lv : lv);
   endtask

   // sender bursts with random gaps
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 1) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
   endtask

   // let every result drain, then allow the pipeline to empty of key events
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      logic [31:0] want;
      logic [31:0] rd;
      bit rdy;
      case (idx)
         REG_ENGINE_RATE: begin cfg_engine_rate = val[15:0]; want = {16'h0, val[15:0]}; end
         REG_BRAKE_RATE:  begin cfg_brake_rate  = val[15:0]; want = {16'h0, val[15:0]}; end
         REG_STEER_RATE:  begin cfg_steer_rate  = val[15:0]; want = {16'h0, val[15:0]}; end
         REG_DEADBAND:    begin cfg_deadband    = val[14:0]; want = {17'h0, val[14:0]}; end
         default:         begin cfg_keys_en     = val[0];    want = {31'h0, val[0]}; end
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = pready;
         @(posedge clock);
      end while (!rdy);
      // read back straight after the write
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = pready;
         rd  = prdata;
         @(posedge clock);
      end while (!rdy);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== want) begin
         $display("%0t: register %0d read expected %0d, got %0d", $time, idx, want, rd);
         error_count++;
      end
   endtask

   initial begin
      logic [15:0] r_eng, r_brk, r_str;
      logic [14:0] r_db;
      logic        r_en;
      int          tick_pct;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset settings
      foreach (directed_rows[i]) begin
         pace();
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].levels);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain_idle();
         r_eng = 16'($urandom);
         r_brk = 16'($urandom);
         r_str = 16'($urandom);
         r_db  = 15'($urandom_range(0, 16384));
         r_en  = ($urandom_range(0, 9) != 0);
         case (ph)
            0: begin
               r_eng = 16'hFFFF; r_brk = 16'hFFFF; r_str = 16'hFFFF;
               r_db  = 15'd16384; r_en = 1'b1;
            end
            1: begin
               r_eng = 16'h0; r_brk = 16'h0; r_str = 16'h0; r_db = 15'd0; r_en = 1'b1;
            end
            2: r_en = 1'b0;
            3: r_en = 1'b1;
            default: ;
         endcase
         csr_write(REG_ENGINE_RATE, {16'h0, r_eng});
         csr_write(REG_BRAKE_RATE,  {16'h0, r_brk});
         csr_write(REG_STEER_RATE,  {16'h0, r_str});
         csr_write(REG_DEADBAND,    {17'h0, r_db});
         csr_write(REG_KEYS_EN,     {31'h0, r_en});
         // with keys off, mostly ticks so the held state keeps ramping
         tick_pct = r_en ? 45 : 80;
         repeat (PHASE_ITEMS) begin
            pace();
            send_item(random_item(tick_pct), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
